@@ hw/rtl/chm_pkg.sv @@
// Shared types and codes for the chained hash map engine.
package chm_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CFG_W = 7;
	localparam int REQ_W = 2;
	localparam int STS_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_GET    = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK     = 2'd0,
		STS_ABSENT = 2'd1,
		STS_FULL   = 2'd2,
		STS_RSVD   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_HEAD,
		S_HWAIT,
		S_WALK,
		S_NWAIT,
		S_FWAIT
	} state_t;

endpackage

@@ hw/rtl/chm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/chm_mod.sv @@
// Bit-serial unit for key modulo bucket count, one key bit per cycle.
module chm_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [chm_pkg::KEY_W-1:0] key,
	input  logic [chm_pkg::CFG_W-1:0] divisor,
	output logic                      done,
	output logic [chm_pkg::CFG_W-1:0] rem
);
	localparam int CW = $clog2(chm_pkg::KEY_W);

	logic                      run_q;
	logic [CW-1:0]             cnt_q;
	logic [chm_pkg::KEY_W-1:0] sh_q;
	logic [chm_pkg::CFG_W-1:0] rem_q;
	logic [chm_pkg::CFG_W:0]   trial;
	logic [chm_pkg::CFG_W-1:0] rem_nxt;

	always_comb begin
		trial = {rem_q, sh_q[chm_pkg::KEY_W-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_nxt = chm_pkg::CFG_W'(trial - {1'b0, divisor});
		end else begin
			rem_nxt = trial[chm_pkg::CFG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(chm_pkg::KEY_W - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= key;
			rem_q <= '0;
		end else if (run_q) begin
			sh_q  <= {sh_q[chm_pkg::KEY_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign rem = rem_q;
endmodule

@@ hw/rtl/chained_hash_map_engine.sv @@
// Top level: request sequencer around bucket, node and free-stack memories.
//
//  channel   | handshake         | payload
//  ----------+-------------------+---------------------------
//  request   | start / busy      | req_type, key, value
//  result    | done (one cycle)  | status, value_out
//  config    | cfg_we            | cfg_wdata (bucket count)
//
// From the accepting edge, an item passes the serial modulo (S_MOD), the bucket
// head read (S_HEAD, S_HWAIT) and an S_WALK and S_NWAIT pair per chain node
// examined, then ends on a hit; a miss ends in S_WALK and an insert of a new key
// adds S_FWAIT; request type 3 ends at the head read. The result strobe
// follows in the cycle in which the next item may already be accepted.
// After reset a clearing pass over max(BUCKETS, NODES) addresses fills the bucket
// heads and the free stack; busy stays high meanwhile. The result strobe
// cannot be stalled.
module chained_hash_map_engine #(
	parameter int BUCKETS = 64,
	parameter int NODES   = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [chm_pkg::REQ_W-1:0] req_type,
	input  logic [chm_pkg::KEY_W-1:0] key,
	input  logic [chm_pkg::VAL_W-1:0] value,
	output logic                      done,
	output logic [chm_pkg::STS_W-1:0] status,
	output logic [chm_pkg::VAL_W-1:0] value_out,
	input  logic                      cfg_we,
	input  logic [chm_pkg::CFG_W-1:0] cfg_wdata
);
	localparam int BW  = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
	localparam int NIW = $clog2(NODES);
	localparam int NW  = NIW + 1;
	localparam int SMAX = BUCKETS > NODES ? BUCKETS : NODES;
	localparam int SW  = $clog2(SMAX) + 1;
	localparam int ND_W = chm_pkg::KEY_W + chm_pkg::VAL_W + NW;
	localparam logic [NW-1:0] NIL = NW'(NODES);

	chm_pkg::state_t state_q, state_d;

	logic [chm_pkg::CFG_W-1:0] bcnt_q;
	logic [chm_pkg::CFG_W-1:0] divisor;
	logic [SW-1:0]             sweep_q;
	logic [chm_pkg::REQ_W-1:0] req_q;
	logic [chm_pkg::KEY_W-1:0] key_q;
	logic [chm_pkg::VAL_W-1:0] val_q;
	logic [BW-1:0]             b_q;
	logic [NW-1:0]             cur_q, prev_q, head_q, steps_q, free_q;
	logic [chm_pkg::KEY_W-1:0] pkey_q;
	logic [chm_pkg::VAL_W-1:0] pval_q;

	logic                      mod_start, mod_done;
	logic [chm_pkg::CFG_W-1:0] mod_rem;

	logic          hd_we;
	logic [BW-1:0] hd_waddr, hd_raddr;
	logic [NW-1:0] hd_wdata, hd_rdata;
	logic           nd_we;
	logic [NIW-1:0] nd_waddr, nd_raddr;
	logic [ND_W-1:0] nd_wdata, nd_rdata;
	logic           fs_we;
	logic [NIW-1:0] fs_waddr, fs_raddr, fs_wdata, fs_rdata;

	logic [chm_pkg::KEY_W-1:0] nd_key;
	logic [chm_pkg::VAL_W-1:0] nd_val;
	logic [NW-1:0]             nd_link;
	logic                      hit;

	logic                      fin;
	logic [chm_pkg::STS_W-1:0] fin_sts;
	logic [chm_pkg::VAL_W-1:0] fin_val;
	logic                      acc;

	assign acc = start && !busy;
	assign busy = (state_q != chm_pkg::S_IDLE);
	assign {nd_key, nd_val, nd_link} = nd_rdata;
	assign hit = (nd_key == key_q);

	// Out-of-range counts: zero acts as one, above BUCKETS acts as BUCKETS.
	always_comb begin
		if (bcnt_q == '0) begin
			divisor = chm_pkg::CFG_W'(1);
		end else if (int'(bcnt_q) > BUCKETS) begin
			divisor = chm_pkg::CFG_W'(BUCKETS);
		end else begin
			divisor = bcnt_q;
		end
	end

	assign mod_start = acc;

	chm_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.key     (key),
		.divisor (divisor),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	chm_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.raddr(hd_raddr), .rdata(hd_rdata)
	);

	chm_ram #(.WIDTH(ND_W), .DEPTH(NODES)) u_node (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.raddr(nd_raddr), .rdata(nd_rdata)
	);

	chm_ram #(.WIDTH(NIW), .DEPTH(NODES)) u_free (
		.clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr), .rdata(fs_rdata)
	);

	always_comb begin
		state_d  = state_q;
		hd_we    = 1'b0;
		hd_waddr = b_q;
		hd_wdata = nd_link;
		hd_raddr = b_q;
		nd_we    = 1'b0;
		nd_waddr = NIW'(cur_q);
		nd_wdata = {key_q, val_q, nd_link};
		nd_raddr = NIW'(cur_q);
		fs_we    = 1'b0;
		fs_waddr = NIW'(free_q);
		fs_wdata = NIW'(cur_q);
		fs_raddr = NIW'(free_q - 1'b1);
		fin      = 1'b0;
		fin_sts  = chm_pkg::STS_OK;
		fin_val  = '0;
		case (state_q)
			chm_pkg::S_CLEAR: begin
				hd_we    = (int'(sweep_q) < BUCKETS);
				hd_waddr = BW'(sweep_q);
				hd_wdata = NIL;
				fs_we    = (int'(sweep_q) < NODES);
				fs_waddr = NIW'(sweep_q);
				fs_wdata = NIW'(sweep_q);
				if (sweep_q == SW'(SMAX - 1)) begin
					state_d = chm_pkg::S_IDLE;
				end
			end
			chm_pkg::S_IDLE: begin
				if (acc) begin
					state_d = chm_pkg::S_MOD;
				end
			end
			chm_pkg::S_MOD: begin
				if (mod_done) begin
					state_d = chm_pkg::S_HEAD;
				end
			end
			chm_pkg::S_HEAD: begin
				state_d = chm_pkg::S_HWAIT;
			end
			chm_pkg::S_HWAIT: begin
				if (req_q == chm_pkg::REQ_NONE) begin
					fin     = 1'b1;
					state_d = chm_pkg::S_IDLE;
				end else begin
					state_d = chm_pkg::S_WALK;
				end
			end
			chm_pkg::S_WALK: begin
				if (cur_q >= NIL || steps_q == NIL) begin
					// Key absent: allocate on insert while a node is free, else report full or absent.
					if (req_q == chm_pkg::REQ_INSERT) begin
						if (free_q == '0) begin
							fin     = 1'b1;
							fin_sts = chm_pkg::STS_FULL;
							state_d = chm_pkg::S_IDLE;
						end else begin
							state_d = chm_pkg::S_FWAIT;
						end
					end else begin
						fin     = 1'b1;
						fin_sts = chm_pkg::STS_ABSENT;
						state_d = chm_pkg::S_IDLE;
					end
				end else begin
					state_d = chm_pkg::S_NWAIT;
				end
			end
			chm_pkg::S_NWAIT: begin
				if (hit) begin
					fin     = 1'b1;
					state_d = chm_pkg::S_IDLE;
					case (req_q)
						chm_pkg::REQ_INSERT: begin
							nd_we = 1'b1;
						end
						chm_pkg::REQ_GET: begin
							fin_val = nd_val;
						end
						chm_pkg::REQ_DELETE: begin
							// Unlink from predecessor or head, push node.
							if (prev_q == NIL) begin
								hd_we = 1'b1;
							end else begin
								nd_we    = 1'b1;
								nd_waddr = NIW'(prev_q);
								nd_wdata = {pkey_q, pval_q, nd_link};
							end
							fs_we = (free_q < NIL);
						end
						default: begin
						end
					endcase
				end else begin
					state_d = chm_pkg::S_WALK;
				end
			end
			chm_pkg::S_FWAIT: begin
				nd_we    = 1'b1;
				nd_waddr = fs_rdata;
				nd_wdata = {key_q, val_q, head_q};
				hd_we    = 1'b1;
				hd_wdata = {1'b0, fs_rdata};
				fin      = 1'b1;
				state_d  = chm_pkg::S_IDLE;
			end
			default: begin
				state_d = chm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chm_pkg::S_CLEAR;
			sweep_q <= '0;
			bcnt_q  <= chm_pkg::CFG_W'(64);
			free_q  <= NIL;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= fin;
			if (state_q == chm_pkg::S_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cfg_we) begin
				bcnt_q <= cfg_wdata;
			end
			if (state_q == chm_pkg::S_WALK && state_d == chm_pkg::S_FWAIT) begin
				free_q <= free_q - 1'b1;
			end else if (fs_we && state_q == chm_pkg::S_NWAIT) begin
				free_q <= free_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			status    <= fin_sts;
			value_out <= fin_val;
		end
		if (acc) begin
			req_q <= req_type;
			key_q <= key;
			val_q <= value;
		end
		if (mod_done) begin
			b_q <= BW'(mod_rem);
		end
		if (state_q == chm_pkg::S_HWAIT) begin
			cur_q   <= hd_rdata;
			head_q  <= hd_rdata;
			prev_q  <= NIL;
			steps_q <= '0;
		end else if (state_q == chm_pkg::S_NWAIT && !hit) begin
			// Advance along the chain, keep the predecessor entry.
			prev_q  <= cur_q;
			pkey_q  <= nd_key;
			pval_q  <= nd_val;
			cur_q   <= nd_link;
			steps_q <= steps_q + 1'b1;
		end
	end
endmodule

@@ hw/rtl/chm_check.sv @@
// Port-level checks for the chained hash map engine, bound to the top level.
module chm_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [chm_pkg::STS_W-1:0] status,
	input logic [chm_pkg::VAL_W-1:0] value_out
);
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == chm_pkg::STS_ABSENT || status == chm_pkg::STS_FULL)
			|-> value_out == '0)
		else $error("nonzero value on miss or full");

	a_sts_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != chm_pkg::STS_RSVD)
		else $error("reserved status code");
endmodule

bind chained_hash_map_engine chm_check u_chm_check (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .value_out(value_out)
);
